FILE: hdl/pba_pkg.sv
// shared constants and transfer types for the page bitmap allocator
package pba_pkg;

   localparam int MAX_PAGES = 1024;
   localparam int WORD_BITS = 32;
   localparam int NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int PAGE_W    = $clog2(MAX_PAGES);
   localparam int POS_W     = PAGE_W + 1;
   localparam int WORD_AW   = $clog2(WORD_BITS);
   localparam int ADDR_W    = $clog2(NUM_WORDS);
   localparam int CHUNK     = 8;
   localparam int CHUNK_AW  = $clog2(CHUNK);

   localparam int COUNT_W   = 10;
   localparam int TOTAL_W   = 11;
   localparam int RESV_W    = 10;
   localparam int CSR_DATA_W = 11;
   localparam int CMP_W     = (POS_W > TOTAL_W ? POS_W : TOTAL_W) + 1;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic CSR_TOTAL_PAGES    = 1'b0;
   localparam logic CSR_RESERVED_PAGES = 1'b1;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET    = TOTAL_W'(MAX_PAGES);
   localparam logic [RESV_W-1:0]  RESERVED_RESET = RESV_W'(1);

   typedef struct packed {
      logic               operation;
      logic [COUNT_W-1:0] page_count;
      logic [PAGE_W-1:0]  first_page;
   } req_type;

   typedef struct packed {
      logic [PAGE_W-1:0] granted_page;
      logic              success;
   } rsp_type;

endpackage

FILE: hdl/page_bitmap_next_fit_allocator.sv
// page bitmap allocator with next-fit run search, top level
//
// channel   ports                              transfer when
// request   start, busy, req_data              start high and busy low
// response  rsp_strobe, rsp_data               rsp_strobe high (one cycle, no stall)
// config    csr_we, csr_index, csr_wdata       csr_we high
//
// one request at a time; busy stays high until its response is issued
// allocate: the scan unit checks 8 pages a cycle, with the next word prefetched so the
//   scan does not pause between words; two passes worst case, then each word touched by
//   the run is read, then written back to mark it
// release: read, then write back each word touched; zero page count answers next cycle
// reset clears per-word valid flags at once, no clearing pass; invalid words read as free
module page_bitmap_next_fit_allocator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  pba_pkg::req_type                   req_data,
   output logic                               rsp_strobe,
   output pba_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [pba_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_MRD  = 3'd3;
   localparam logic [2:0] ST_MWR  = 3'd4;

   localparam int PW  = pba_pkg::PAGE_W;
   localparam int QW  = pba_pkg::POS_W;
   localparam int AW  = pba_pkg::ADDR_W;
   localparam int WAW = pba_pkg::WORD_AW;
   localparam int CW  = pba_pkg::CMP_W;
   localparam int NW  = pba_pkg::COUNT_W;
   localparam int WB  = pba_pkg::WORD_BITS;

   // control state
   logic [2:0]                        state_ff, state_in;
   logic                              rsp_strobe_ff, rsp_strobe_in;
   logic [pba_pkg::NUM_WORDS-1:0]     valid_ff;
   logic [pba_pkg::TOTAL_W-1:0]       total_ff;
   logic [pba_pkg::RESV_W-1:0]        reserved_ff;
   logic [PW-1:0]                     scan_ff, scan_in;

   // search and update working registers
   logic [QW-1:0]                     pos_ff, pos_in;
   logic [NW-1:0]                     len_ff, len_in;
   logic [PW-1:0]                     start_ff, start_in;
   logic                              pass_ff, pass_in;
   logic [QW-1:0]                     lo_ff, lo_in;
   logic [QW-1:0]                     hi_ff, hi_in;
   logic [NW-1:0]                     n_ff, n_in;
   logic [PW-1:0]                     mlo_ff, mlo_in;
   logic [QW:0]                       mhi_ff, mhi_in;
   logic [AW-1:0]                     wword_ff, wword_in;
   logic [AW-1:0]                     wlast_ff, wlast_in;
   logic                              wset_ff, wset_in;
   pba_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   // bitmap memory
   logic [WB-1:0]                     mem [pba_pkg::NUM_WORDS];
   logic [WB-1:0]                     rd_data_ff;
   logic                              rd_valid_ff;
   logic                              rd_en;
   logic [AW-1:0]                     rd_addr;
   logic                              wr_en;
   logic [WB-1:0]                     wr_data;
   logic [WB-1:0]                     cur_word;
   logic [WB-1:0]                     range_mask;

   // effective totals
   logic [pba_pkg::TOTAL_W-1:0]       tot_eff;
   logic [CW-1:0]                     tot_c;

   // chunk scan unit results
   logic [NW-1:0]                     c_len;
   logic [PW-1:0]                     c_start;
   logic                              c_found;
   logic [CW-1:0]                     c_page;
   logic                              c_busy;
   logic [WAW-1:0]                    c_bit;
   logic [CW-1:0]                     chunk_end;
   logic                              chunk_last;

   // helper sums
   logic [QW:0]                       run_end;
   logic [QW:0]                       run_last;
   logic [QW:0]                       rel_end;
   logic [QW:0]                       rel_last;
   logic [CW-1:0]                     mpage;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   assign tot_eff = (total_ff > pba_pkg::TOTAL_W'(pba_pkg::MAX_PAGES)) ?
                    pba_pkg::TOTAL_W'(pba_pkg::MAX_PAGES) : total_ff;
   assign tot_c   = CW'(tot_eff);

   // a word never written since reset reads as all free
   assign cur_word = rd_valid_ff ? rd_data_ff : '0;

   // scan unit: CHUNK pages per cycle, next-fit run counting
   always_comb begin
      c_len   = len_ff;
      c_start = start_ff;
      c_found = 1'b0;
      c_page  = '0;
      c_busy  = 1'b0;
      c_bit   = '0;
      for (int k = 0; k < pba_pkg::CHUNK; k++) begin
         c_page = CW'(pos_ff) + CW'(k);
         c_bit  = pos_ff[WAW-1:0] + WAW'(k);
         c_busy = (c_page == '0) || (c_page < CW'(reserved_ff)) || (c_page >= tot_c) ||
                  (c_page < CW'(lo_ff)) || (c_page >= CW'(hi_ff)) || cur_word[c_bit];
         if (!c_found) begin
            if (c_busy) begin
               c_len = '0;
            end else begin
               if (c_len == '0) begin
                  c_start = c_page[PW-1:0];
               end
               c_len = c_len + NW'(1);
               if (c_len == n_ff) begin
                  c_found = 1'b1;
               end
            end
         end
      end
   end

   assign chunk_end  = CW'(pos_ff) + CW'(pba_pkg::CHUNK);
   assign chunk_last = &pos_ff[WAW-1:pba_pkg::CHUNK_AW];

   // run bounds for marking an allocation or clearing a release
   assign run_end  = (QW+1)'(c_start) + (QW+1)'(n_ff);
   assign run_last = run_end - (QW+1)'(1);
   assign rel_end  = (QW+1)'(req_data.first_page) + (QW+1)'(req_data.page_count);
   assign rel_last = rel_end - (QW+1)'(1);

   // pages of the current word that fall inside [mlo, mhi)
   always_comb begin
      range_mask = '0;
      mpage      = '0;
      for (int i = 0; i < WB; i++) begin
         mpage = CW'({wword_ff, WAW'(i)});
         range_mask[i] = (mpage >= CW'(mlo_ff)) && (mpage < CW'(mhi_ff));
      end
   end

   assign wr_data = wset_ff ? (cur_word | range_mask) : (cur_word & ~range_mask);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      rsp_strobe_in = 1'b0;
      scan_in       = scan_ff;
      pos_in        = pos_ff;
      len_in        = len_ff;
      start_in      = start_ff;
      pass_in       = pass_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      n_in          = n_ff;
      mlo_in        = mlo_ff;
      mhi_in        = mhi_ff;
      wword_in      = wword_ff;
      wlast_in      = wlast_ff;
      wset_in       = wset_ff;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = pos_ff[PW-1:WAW];
      wr_en         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in   = req_data.page_count;
               len_in = '0;
               if (req_data.page_count == '0) begin
                  // nothing to do, both operations report failure
                  rsp_data_in.granted_page = '0;
                  rsp_data_in.success      = 1'b0;
                  rsp_strobe_in            = 1'b1;
               end else if (req_data.operation == pba_pkg::OP_RELEASE) begin
                  mlo_in   = req_data.first_page;
                  mhi_in   = rel_end;
                  wword_in = req_data.first_page[PW-1:WAW];
                  // pages past the top are dropped
                  wlast_in = (rel_last >= (QW+1)'(pba_pkg::MAX_PAGES)) ?
                             '1 : rel_last[PW-1:WAW];
                  wset_in  = 1'b0;
                  rsp_data_in.granted_page = '0;
                  rsp_data_in.success      = 1'b1;
                  state_in = ST_MRD;
               end else if (CW'(scan_ff) < tot_c) begin
                  // first pass from scan position to the top
                  pass_in  = 1'b0;
                  lo_in    = QW'(scan_ff);
                  hi_in    = QW'(tot_eff);
                  pos_in   = QW'({scan_ff[PW-1:pba_pkg::CHUNK_AW],
                                  pba_pkg::CHUNK_AW'(0)});
                  state_in = ST_RD;
               end else begin
                  // scan position at or past the top: only the wrap pass
                  pass_in  = 1'b1;
                  lo_in    = '0;
                  hi_in    = QW'(tot_eff);
                  pos_in   = '0;
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            rd_en    = 1'b1;
            rd_addr  = pos_ff[PW-1:WAW];
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (c_found) begin
               rsp_data_in.granted_page = c_start;
               rsp_data_in.success      = 1'b1;
               mlo_in   = c_start;
               mhi_in   = run_end;
               wword_in = c_start[PW-1:WAW];
               wlast_in = run_last[PW-1:WAW];
               wset_in  = 1'b1;
               scan_in  = (run_end >= (QW+1)'(pba_pkg::MAX_PAGES)) ? '0 : run_end[PW-1:0];
               state_in = ST_MRD;
            end else if (chunk_end >= CW'(hi_ff)) begin
               if (!pass_ff && (scan_ff != '0)) begin
                  // wrap pass from page 0 up to the scan position
                  pass_in  = 1'b1;
                  lo_in    = '0;
                  hi_in    = QW'(scan_ff);
                  pos_in   = '0;
                  len_in   = '0;
                  state_in = ST_RD;
               end else begin
                  rsp_data_in.granted_page = '0;
                  rsp_data_in.success      = 1'b0;
                  rsp_strobe_in            = 1'b1;
                  state_in                 = ST_IDLE;
               end
            end else begin
               pos_in   = pos_ff + QW'(pba_pkg::CHUNK);
               len_in   = c_len;
               start_in = c_start;
               if (chunk_last) begin
                  // prefetch the next word so the scan keeps going
                  rd_en   = 1'b1;
                  rd_addr = pos_ff[PW-1:WAW] + AW'(1);
               end
            end
         end
         ST_MRD: begin
            rd_en    = 1'b1;
            rd_addr  = wword_ff;
            state_in = ST_MWR;
         end
         ST_MWR: begin
            wr_en = 1'b1;
            if (wword_ff == wlast_ff) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               wword_in = wword_ff + AW'(1);
               state_in = ST_MRD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers and config
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         valid_ff      <= '0;
         scan_ff       <= '0;
         total_ff      <= pba_pkg::TOTAL_RESET;
         reserved_ff   <= pba_pkg::RESERVED_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         scan_ff       <= scan_in;
         if (wr_en) begin
            valid_ff[wword_ff] <= 1'b1;
         end
         if (csr_we) begin
            case (csr_index)
               pba_pkg::CSR_TOTAL_PAGES: begin
                  total_ff <= csr_wdata[pba_pkg::TOTAL_W-1:0];
               end
               pba_pkg::CSR_RESERVED_PAGES: begin
                  reserved_ff <= csr_wdata[pba_pkg::RESV_W-1:0];
               end
               default: begin
                  total_ff <= total_ff;
               end
            endcase
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      len_ff      <= len_in;
      start_ff    <= start_in;
      pass_ff     <= pass_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      n_ff        <= n_in;
      mlo_ff      <= mlo_in;
      mhi_ff      <= mhi_in;
      wword_ff    <= wword_in;
      wlast_ff    <= wlast_in;
      wset_ff     <= wset_in;
      rsp_data_ff <= rsp_data_in;
   end

   // bitmap memory, one port used per cycle, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wword_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

endmodule
